// ----- rtl/fscu_pkg.sv -----
// fscu_pkg: types, bit positions, codes and helper functions for the fpu status unit
// no dependencies; used by fpu_status_condition_unit
package fscu_pkg;

    // operation selector carried with each transaction
    typedef enum logic [1:0] {
        MODE_RECORD = 2'd0,
        MODE_TEST   = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    // trap codes in priority order
    typedef enum logic [2:0] {
        TRAP_NONE  = 3'd0,
        TRAP_SNAN  = 3'd1,
        TRAP_BSUN  = 3'd2,
        TRAP_OPERR = 3'd3,
        TRAP_OVFL  = 3'd4,
        TRAP_UNFL  = 3'd5,
        TRAP_DZ    = 3'd6,
        TRAP_INEX  = 3'd7
    } t_trap;

    // base predicate codes (low three bits of the predicate)
    typedef enum logic [2:0] {
        PRED_F   = 3'd0,
        PRED_EQ  = 3'd1,
        PRED_OGT = 3'd2,
        PRED_OGE = 3'd3,
        PRED_OLT = 3'd4,
        PRED_OLE = 3'd5,
        PRED_OGL = 3'd6,
        PRED_OR  = 3'd7
    } t_pred;

    // exception byte bit positions
    localparam int unsigned EXB_BSUN  = 7;
    localparam int unsigned EXB_SNAN  = 6;
    localparam int unsigned EXB_OPERR = 5;
    localparam int unsigned EXB_OVFL  = 4;
    localparam int unsigned EXB_UNFL  = 3;
    localparam int unsigned EXB_DZ    = 2;
    localparam int unsigned EXB_INEX2 = 1;
    localparam int unsigned EXB_INEX1 = 0;

    // accrued byte bit positions
    localparam int unsigned ACB_IOP  = 4;
    localparam int unsigned ACB_OVFL = 3;
    localparam int unsigned ACB_UNFL = 2;
    localparam int unsigned ACB_DZ   = 1;
    localparam int unsigned ACB_INEX = 0;

    // condition nibble bit positions
    localparam int unsigned CC_N   = 3;
    localparam int unsigned CC_Z   = 2;
    localparam int unsigned CC_I   = 1;
    localparam int unsigned CC_NAN = 0;

    // bit 4 of the predicate marks a signalling test
    localparam int unsigned PRED_SIGNAL = 4;
    // bit 3 of the predicate selects the complemented half
    localparam int unsigned PRED_INVERT = 3;

    typedef struct packed {
        t_mode       mode;
        logic [4:0]  predicate;
        logic [31:0] next_pc;
        logic [3:0]  result_class;
        logic [4:0]  host_flags;
        logic [7:0]  extra_exceptions;
    } t_in_item;

    typedef struct packed {
        logic        condition_true;
        logic [2:0]  trap_code;
        logic [3:0]  status_cond;
        logic [7:0]  exception_status;
        logic [4:0]  accrued_status;
        logic [31:0] instr_address;
    } t_out_item;

    // one of the eight base relations over the condition flags
    function automatic logic base_predicate(input logic [2:0] code, input logic n,
                                            input logic z, input logic nan);
        logic r;
        unique case (t_pred'(code))
            PRED_F:   r = 1'b0;
            PRED_EQ:  r = z;
            PRED_OGT: r = !nan && !z && !n;
            PRED_OGE: r = z || (!nan && !n);
            PRED_OLT: r = !nan && n && !z;
            PRED_OLE: r = z || (!nan && n);
            PRED_OGL: r = !nan && !z;
            PRED_OR:  r = !nan;
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

    // highest priority enabled exception
    function automatic t_trap pick_trap(input logic [7:0] pending);
        t_trap t;
        priority if (pending[EXB_SNAN])                      t = TRAP_SNAN;
        else if (pending[EXB_BSUN])                          t = TRAP_BSUN;
        else if (pending[EXB_OPERR])                         t = TRAP_OPERR;
        else if (pending[EXB_OVFL])                          t = TRAP_OVFL;
        else if (pending[EXB_UNFL])                          t = TRAP_UNFL;
        else if (pending[EXB_DZ])                            t = TRAP_DZ;
        else if (pending[EXB_INEX1] || pending[EXB_INEX2])   t = TRAP_INEX;
        else                                                 t = TRAP_NONE;
        return t;
    endfunction

endpackage

// ----- rtl/fpu_status_condition_unit.sv -----
// fpu_status_condition_unit: status, accrued and trap logic plus predicate test
// depends on fscu_pkg for transaction types, bit positions and helper functions

// The unit takes one transaction per clock cycle and returns one result per
// transaction: an input register holds the transaction, the status update and
// predicate test are evaluated combinationally from it and the status
// registers, and the outcome is held in a result register. Throughput is set by
// that single read-modify-write of the status registers, so a full cycle rate
// is kept while downstream takes results; a stalled result register holds the
// input register, and the input side then stalls. The trap enable byte is
// written through i_cfg_we / i_cfg_wdata and should only change while no
// transaction is in flight.
module fpu_status_condition_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fscu_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fscu_pkg::t_out_item o_out_data
);
    import fscu_pkg::*;

    logic        r_trap_enable;
    logic [7:0]  r_trap_en;
    logic [3:0]  r_cond,   n_cond;
    logic [7:0]  r_exc,    n_exc;
    logic [4:0]  r_acc,    n_acc;
    logic [31:0] r_fault,  n_fault;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out, n_out;

    logic        out_free;
    logic        advance;
    logic        in_take;

    // handshake flow between the two register stages
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !out_free;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trap_en     <= '0;
            r_trap_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_trap_en     <= i_cfg_wdata;
            r_trap_enable <= |i_cfg_wdata;
        end
    end

    // status update and predicate evaluation for the held transaction
    always_comb begin
        logic [7:0] ex;
        logic [7:0] pending;
        logic       nan;
        logic       bsun;
        logic       rel;
        logic [2:0] code;
        t_trap      trap;
        logic       cond_out;

        n_cond   = r_cond;
        n_exc    = r_exc;
        n_acc    = r_acc;
        n_fault  = r_fault;
        trap     = TRAP_NONE;
        cond_out = 1'b0;
        ex       = '0;
        pending  = '0;
        nan      = r_cond[CC_NAN];
        bsun     = 1'b0;
        rel      = 1'b0;
        code     = '0;

        unique case (r_in.mode)
            MODE_RECORD: begin
                ex      = r_exc | {2'b00, r_in.host_flags, 1'b0} | r_in.extra_exceptions;
                n_exc   = ex;
                n_cond  = r_in.result_class;
                if (ex[EXB_BSUN] || ex[EXB_SNAN] || ex[EXB_OPERR]) n_acc[ACB_IOP] = 1'b1;
                if (ex[EXB_OVFL]) n_acc[ACB_OVFL] = 1'b1;
                if (ex[EXB_UNFL] && ex[EXB_INEX2]) n_acc[ACB_UNFL] = 1'b1;
                if (ex[EXB_DZ]) n_acc[ACB_DZ] = 1'b1;
                if (ex[EXB_INEX1] || ex[EXB_INEX2] || ex[EXB_OVFL]) n_acc[ACB_INEX] = 1'b1;
                pending = ex & r_trap_en;
                if (r_trap_enable && (|pending)) begin
                    n_fault = r_in.next_pc;
                    trap    = pick_trap(pending);
                end
            end
            MODE_TEST: begin
                bsun = r_in.predicate[PRED_SIGNAL] && nan;
                if (bsun) begin
                    n_exc[EXB_BSUN] = 1'b1;
                    n_acc[ACB_IOP]  = 1'b1;
                    if (r_trap_en[EXB_BSUN]) begin
                        n_fault = r_in.next_pc;
                        trap    = TRAP_BSUN;
                    end
                end
                // upper half is the complement of the mirrored base relation
                code = r_in.predicate[PRED_INVERT] ? ~r_in.predicate[2:0]
                                                   : r_in.predicate[2:0];
                rel  = base_predicate(code, r_cond[CC_N], r_cond[CC_Z], nan);
                if (trap == TRAP_NONE) begin
                    cond_out = rel ^ r_in.predicate[PRED_INVERT];
                end
            end
            MODE_CLEAR: begin
                n_exc = '0;
            end
            default: begin
                // unused mode leaves the state alone
            end
        endcase

        n_out.condition_true   = cond_out;
        n_out.trap_code        = trap;
        n_out.status_cond      = n_cond;
        n_out.exception_status = n_exc;
        n_out.accrued_status   = n_acc;
        n_out.instr_address    = n_fault;
    end

    // status registers, updated as each transaction leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cond  <= '0;
            r_exc   <= '0;
            r_acc   <= '0;
            r_fault <= '0;
        end else if (advance) begin
            r_cond  <= n_cond;
            r_exc   <= n_exc;
            r_acc   <= n_acc;
            r_fault <= n_fault;
        end
    end

    // input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // result stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- tb/tb_fpu_status_condition_unit.sv -----
// tb_fpu_status_condition_unit: self-checking testbench for the fpu status and condition unit
// depends on fscu_pkg (transaction types, codes, bit positions) and fpu_status_condition_unit
// a status tracker class predicts every result; directed then random phases over trap enables
module tb_fpu_status_condition_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fscu_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int PHASE_COUNT     = 7;
    localparam int ITEMS_PER_PHASE = 270;
    localparam int MAX_REPORTS     = 100;

    // status tracker: own copy of the unit's registers and the results still owed
    class status_tracker;
        logic [7:0]  trap_en;
        logic [7:0]  exc_byte;
        logic [3:0]  cond;
        logic [4:0]  acc;
        logic [31:0] fault;
        t_out_item   expected_results[$];
        int          errors;

        function new();
            trap_en  = '0;
            exc_byte = '0;
            cond     = '0;
            acc      = '0;
            fault    = '0;
            errors   = 0;
        endfunction

        function void set_trap_enable(input logic [7:0] value);
            trap_en = value;
        endfunction

        // base relation over the current condition nibble
        function logic relation(input logic [2:0] code);
            logic n, z, nan;
            n   = cond[CC_N];
            z   = cond[CC_Z];
            nan = cond[CC_NAN];
            case (t_pred'(code))
                PRED_F:   return 1'b0;
                PRED_EQ:  return z;
                PRED_OGT: return !nan && !z && !n;
                PRED_OGE: return z || (!nan && !n);
                PRED_OLT: return !nan && n && !z;
                PRED_OLE: return z || (!nan && n);
                PRED_OGL: return !nan && !z;
                default:  return !nan;
            endcase
        endfunction

        // fixed trap priority over the enabled pending bits
        function t_trap highest_trap(input logic [7:0] pending);
            if (pending[EXB_SNAN])  return TRAP_SNAN;
            if (pending[EXB_BSUN])  return TRAP_BSUN;
            if (pending[EXB_OPERR]) return TRAP_OPERR;
            if (pending[EXB_OVFL])  return TRAP_OVFL;
            if (pending[EXB_UNFL])  return TRAP_UNFL;
            if (pending[EXB_DZ])    return TRAP_DZ;
            if (pending[EXB_INEX1] || pending[EXB_INEX2]) return TRAP_INEX;
            return TRAP_NONE;
        endfunction

        // update the tracked state for one accepted transaction and queue its result
        function void record_transaction(input t_in_item it);
            t_out_item  r;
            t_trap      trap;
            logic [7:0] ex;
            logic [7:0] pending;
            logic [3:0] code;
            logic       hit;
            r    = '0;
            trap = TRAP_NONE;
            hit  = 1'b0;
            case (it.mode)
                MODE_RECORD: begin
                    ex       = exc_byte | {2'b00, it.host_flags, 1'b0} | it.extra_exceptions;
                    exc_byte = ex;
                    cond     = it.result_class;
                    if (ex[EXB_BSUN] || ex[EXB_SNAN] || ex[EXB_OPERR]) acc[ACB_IOP] = 1'b1;
                    if (ex[EXB_OVFL]) acc[ACB_OVFL] = 1'b1;
                    if (ex[EXB_UNFL] && ex[EXB_INEX2]) acc[ACB_UNFL] = 1'b1;
                    if (ex[EXB_DZ]) acc[ACB_DZ] = 1'b1;
                    if (ex[EXB_INEX1] || ex[EXB_INEX2] || ex[EXB_OVFL]) acc[ACB_INEX] = 1'b1;
                    pending = ex & trap_en;
                    if (pending != 8'h00) begin
                        fault = it.next_pc;
                        trap  = highest_trap(pending);
                    end
                end
                MODE_TEST: begin
                    // signalling predicate on a nan raises bsun and may trap
                    if (it.predicate[PRED_SIGNAL] && cond[CC_NAN]) begin
                        exc_byte[EXB_BSUN] = 1'b1;
                        acc[ACB_IOP]       = 1'b1;
                        if (trap_en[EXB_BSUN]) begin
                            fault = it.next_pc;
                            trap  = TRAP_BSUN;
                        end
                    end
                    if (trap == TRAP_NONE) begin
                        code = it.predicate[3:0];
                        if (code[PRED_INVERT])
                            hit = !relation(3'(4'd15 - code));
                        else
                            hit = relation(code[2:0]);
                    end
                end
                MODE_CLEAR: begin
                    exc_byte = '0;
                end
                default: begin
                end
            endcase
            r.condition_true   = hit;
            r.trap_code        = trap;
            r.status_cond      = cond;
            r.exception_status = exc_byte;
            r.accrued_status   = acc;
            r.instr_address    = fault;
            expected_results.push_back(r);
        endfunction

        function void report(input string field, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0h actual %0h",
                         $time, field, exp_val, act_val);
        endfunction

        // compare one delivered result against the oldest one owed
        function void compare_result(input t_out_item act);
            t_out_item e;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t ns: result with no transaction pending, actual %0h", $time, act);
                return;
            end
            e = expected_results.pop_front();
            if (act.condition_true !== e.condition_true)
                report("condition_true", 32'(e.condition_true), 32'(act.condition_true));
            if (act.trap_code !== e.trap_code)
                report("trap_code", 32'(e.trap_code), 32'(act.trap_code));
            if (act.status_cond !== e.status_cond)
                report("status_cond", 32'(e.status_cond), 32'(act.status_cond));
            if (act.exception_status !== e.exception_status)
                report("exception_status", 32'(e.exception_status),
                       32'(act.exception_status));
            if (act.accrued_status !== e.accrued_status)
                report("accrued_status", 32'(e.accrued_status), 32'(act.accrued_status));
            if (act.instr_address !== e.instr_address)
                report("instr_address", e.instr_address, act.instr_address);
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic [7:0] i_cfg_wdata;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    status_tracker tracker;
    logic          quiet;
    int            idle_cycles = 0;

    fpu_status_condition_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // random idle decision, suppressed during the quiet stretch
    function automatic logic draw_idle();
        if (quiet)
            return 1'b0;
        return $urandom_range(99) < 23;
    endfunction

    // downstream back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= draw_idle();
    end

    // monitor: note accepted transactions, check results, watch for a hang
    always @(posedge i_clk) begin : monitor
        logic in_acc, out_acc;
        in_acc  = i_rst_n && i_in_valid && (o_in_stall === 1'b0);
        out_acc = i_rst_n && (o_out_valid === 1'b1) && !i_out_stall;
        if (in_acc)
            tracker.record_transaction(i_in_data);
        if (out_acc)
            tracker.compare_result(o_out_data);
        if (in_acc || out_acc)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_in_item make_item(input logic [1:0] mode, input logic [4:0] pred,
                                           input logic [31:0] pc, input logic [3:0] cls,
                                           input logic [4:0] host, input logic [7:0] extra);
        t_in_item it;
        it.mode             = t_mode'(mode);
        it.predicate        = pred;
        it.next_pc          = pc;
        it.result_class     = cls;
        it.host_flags       = host;
        it.extra_exceptions = extra;
        return it;
    endfunction

    // random transaction; sparse exception inputs keep the sticky byte from saturating
    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 45)
            it.mode = MODE_RECORD;
        else if (pick < 82)
            it.mode = MODE_TEST;
        else
            it.mode = MODE_CLEAR;
        it.predicate    = 5'($urandom_range(31));
        it.next_pc      = $urandom();
        it.result_class = 4'($urandom_range(15));
        it.host_flags   = $urandom_range(1) ? 5'h00 : 5'($urandom_range(31));
        pick = $urandom_range(9);
        if (pick < 6)
            it.extra_exceptions = 8'h00;
        else if (pick < 9)
            it.extra_exceptions = 8'(1 << $urandom_range(7));
        else
            it.extra_exceptions = 8'($urandom_range(255));
        return it;
    endfunction

    // present one transaction after optional idle cycles, hold it until accepted
    task automatic send_item(input t_in_item it);
        while (draw_idle()) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // stop sending and wait until every owed result has come back
    task automatic drain();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.expected_results.size() != 0 && waited < STALL_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_trap_enable(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        tracker.set_trap_enable(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [7:0] phase_te [PHASE_COUNT];
        int         p, k;
        tracker     = new();
        quiet       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        phase_te    = '{8'h00, 8'hff, 8'h80, 8'h00, 8'h01, 8'h00, 8'h7f};
        phase_te[3] = 8'($urandom_range(255));
        phase_te[5] = 8'($urandom_range(255));

        // reset
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, traps disabled: field extremes, every mode, unused mode
        write_trap_enable(8'h00);
        send_item(make_item(MODE_RECORD, 5'h00, 32'h0000_0000, 4'h0, 5'h00, 8'h00));
        send_item(make_item(MODE_RECORD, 5'h1f, 32'hffff_ffff, 4'hf, 5'h1f, 8'hff));
        send_item(make_item(MODE_TEST,   5'h1f, 32'hffff_ffff, 4'h0, 5'h00, 8'h00));
        send_item(make_item(MODE_TEST,   5'h0f, 32'h0000_0000, 4'h0, 5'h00, 8'h00));
        send_item(make_item(MODE_CLEAR,  5'h00, 32'h0000_0000, 4'h0, 5'h00, 8'h00));
        send_item(make_item(2'd3,        5'h1f, 32'hffff_ffff, 4'hf, 5'h1f, 8'hff));
        send_item(make_item(MODE_TEST,   5'h00, 32'h0000_0001, 4'h0, 5'h00, 8'h00));
        drain();

        // directed, all traps enabled: sticky trap, signalling trap, priority
        write_trap_enable(8'hff);
        send_item(make_item(MODE_RECORD, 5'h00, 32'h1234_5678, 4'h1, 5'h00, 8'h40));
        send_item(make_item(MODE_RECORD, 5'h00, 32'h8765_4321, 4'h8, 5'h00, 8'h00));
        send_item(make_item(MODE_TEST,   5'h10, 32'h0bad_f00d, 4'h0, 5'h00, 8'h00));
        send_item(make_item(MODE_RECORD, 5'h00, 32'h0000_0100, 4'h1, 5'h00, 8'h00));
        send_item(make_item(MODE_CLEAR,  5'h00, 32'h0000_0000, 4'h0, 5'h00, 8'h00));
        send_item(make_item(MODE_TEST,   5'h10, 32'hdead_beef, 4'h0, 5'h00, 8'h00));
        send_item(make_item(MODE_CLEAR,  5'h00, 32'h0000_0000, 4'h0, 5'h00, 8'h00));
        send_item(make_item(MODE_RECORD, 5'h00, 32'haaaa_5555, 4'h2, 5'h05, 8'h00));
        send_item(make_item(MODE_CLEAR,  5'h00, 32'h0000_0000, 4'h0, 5'h00, 8'h00));
        send_item(make_item(MODE_RECORD, 5'h00, 32'h5555_aaaa, 4'h9, 5'h10, 8'h00));
        send_item(make_item(MODE_CLEAR,  5'h00, 32'h0000_0000, 4'h0, 5'h00, 8'h00));
        send_item(make_item(MODE_RECORD, 5'h00, 32'h0000_ff00, 4'ha, 5'h02, 8'h00));
        send_item(make_item(MODE_CLEAR,  5'h00, 32'h0000_0000, 4'h0, 5'h00, 8'h00));
        send_item(make_item(MODE_RECORD, 5'h00, 32'h00ff_0000, 4'h4, 5'h00, 8'h01));
        send_item(make_item(MODE_TEST,   5'h01, 32'h0000_0000, 4'h0, 5'h00, 8'h00));
        send_item(make_item(MODE_TEST,   5'h0e, 32'h0000_0000, 4'h0, 5'h00, 8'h00));
        send_item(make_item(MODE_CLEAR,  5'h00, 32'h0000_0000, 4'h0, 5'h00, 8'h00));
        drain();

        // random phases, one trap enable setting each
        for (p = 0; p < PHASE_COUNT; p++) begin
            write_trap_enable(phase_te[p]);
            quiet = (p == 2);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // sender holds off mid-phase until the pipeline is empty
                if (p == 1 && k == ITEMS_PER_PHASE / 2)
                    drain();
                send_item(random_item());
            end
            quiet = 1'b0;
            drain();
        end

        // leftovers count as failures
        tracker.errors += tracker.expected_results.size();
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
